/* sv/alpha_blend_pixel_rgb565_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend pixel core
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_PIXEL_RGB565_CORE_MACROS_SVH
`define ALPHA_BLEND_PIXEL_RGB565_CORE_MACROS_SVH

// same-cycle implication
`define ABP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abp assertion failed");

// next-cycle implication
`define ABP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abp assertion failed");

`endif

/* sv/abp_pkg.sv */
// ----------------------------------------------------------------------------
// abp_pkg
// Constants and types shared by the alpha blend pixel core.
// ----------------------------------------------------------------------------
package abp_pkg;

	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 320;

	localparam int COORD_W = 12;
	localparam int CH_W    = 8;
	localparam int PIX_W   = 16;
	localparam int IDX_W   = 17;

	localparam int IDX_SPAN  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int IDX_LIMIT = (IDX_SPAN > (1 << IDX_W)) ? (1 << IDX_W) : IDX_SPAN;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} abp_adv_t;

endpackage

/* sv/abp_mix.sv */
// ----------------------------------------------------------------------------
// abp_mix
// One color channel: (s*a + d*(255-a)) / 255, floor, over three stages.
// ----------------------------------------------------------------------------
module abp_mix (
	input  logic                       clk,
	input  abp_pkg::abp_adv_t          adv,
	input  logic [abp_pkg::CH_W-1:0]   s,
	input  logic [abp_pkg::CH_W-1:0]   d,
	input  logic [abp_pkg::CH_W-1:0]   a,
	output logic [abp_pkg::CH_W-1:0]   q
);

	logic [abp_pkg::CH_W-1:0]   a_inv;
	logic [2*abp_pkg::CH_W-1:0] ps_s1;
	logic [2*abp_pkg::CH_W-1:0] pd_s1;
	logic [2*abp_pkg::CH_W-1:0] sum_s2;
	logic [2*abp_pkg::CH_W-1:0] recip;
	logic [abp_pkg::CH_W-1:0]   q_s3;

	// 255 - a at channel width
	assign a_inv = ~a;

	// n/255 == (n + 1 + (n >> 8)) >> 8 for every n up to 255*255, the largest sum here
	assign recip = sum_s2 + 16'd1 + (sum_s2 >> abp_pkg::CH_W);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ps_s1 <= s * a;
			pd_s1 <= d * a_inv;
		end
		if (adv.s2) begin
			sum_s2 <= ps_s1 + pd_s1;
		end
		if (adv.s3) begin
			q_s3 <= recip[2*abp_pkg::CH_W-1:abp_pkg::CH_W];
		end
	end

	assign q = q_s3;

endmodule

/* sv/abp_index.sv */
// ----------------------------------------------------------------------------
// abp_index
// Linear framebuffer index row * width + column, over three stages.
// ----------------------------------------------------------------------------
module abp_index (
	input  logic                        clk,
	input  abp_pkg::abp_adv_t           adv,
	input  logic [abp_pkg::COORD_W-2:0] col,
	input  logic [abp_pkg::COORD_W-2:0] row,
	output logic [abp_pkg::IDX_W-1:0]   idx
);

	localparam int PROD_W = 2 * (abp_pkg::COORD_W - 1);

	logic [PROD_W-1:0]           prod;
	logic [abp_pkg::IDX_W-1:0]   rowp_s1;
	logic [abp_pkg::COORD_W-2:0] col_s1;
	logic [abp_pkg::IDX_W-1:0]   idx_s2;
	logic [abp_pkg::IDX_W-1:0]   idx_s3;

	assign prod = PROD_W'(row) * PROD_W'(abp_pkg::SCREEN_WIDTH);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			rowp_s1 <= prod[abp_pkg::IDX_W-1:0];
			col_s1  <= col;
		end
		if (adv.s2) begin
			idx_s2 <= rowp_s1 + abp_pkg::IDX_W'(col_s1);
		end
		if (adv.s3) begin
			idx_s3 <= idx_s2;
		end
	end

	assign idx = idx_s3;

endmodule

/* sv/alpha_blend_pixel_rgb565_core.sv */
// ----------------------------------------------------------------------------
// alpha_blend_pixel_rgb565_core
// Blends an ARGB8888 source pixel over its RGB565 destination pixel.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while pix_stall is low and returns one
// result word for each, in order, through the three-stage pipeline:
// channel multiplies and the row product in the first stage, the channel
// sums and the column add in the second, the divide by 255 in the third,
// which is also the output register. A stall on the result side fills
// empty stages first, then holds the input off.
// Out-of-bounds pixels (negative coordinates included) and alpha 0 return
// write_enable low with index and color zero.
module alpha_blend_pixel_rgb565_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  logic signed [abp_pkg::COORD_W-1:0] pos_x,
	input  logic signed [abp_pkg::COORD_W-1:0] pos_y,
	input  logic [abp_pkg::CH_W-1:0]        src_red,
	input  logic [abp_pkg::CH_W-1:0]        src_green,
	input  logic [abp_pkg::CH_W-1:0]        src_blue,
	input  logic [abp_pkg::CH_W-1:0]        src_alpha,
	input  logic [abp_pkg::PIX_W-1:0]       dest_pixel,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            write_enable,
	output logic [abp_pkg::IDX_W-1:0]       pixel_index,
	output logic [abp_pkg::PIX_W-1:0]       pixel_color
);

	abp_pkg::abp_adv_t adv;
	logic v_s1, v_s2, v_s3;
	logic we_s1, we_s2, we_s3;
	logic x_ok, y_ok, we_in;
	logic [abp_pkg::CH_W-1:0] dr, dg, db;
	logic [abp_pkg::CH_W-1:0] mr, mg, mb;
	logic [abp_pkg::IDX_W-1:0] idx;

	assign adv.s3 = !v_s3 || !res_stall;
	assign adv.s2 = !v_s2 || adv.s3;
	assign adv.s1 = !v_s1 || adv.s2;
	assign pix_stall = !adv.s1;

	assign x_ok = !pos_x[abp_pkg::COORD_W-1] &&
		(pos_x[abp_pkg::COORD_W-2:0] < (abp_pkg::COORD_W-1)'(abp_pkg::SCREEN_WIDTH));
	assign y_ok = !pos_y[abp_pkg::COORD_W-1] &&
		(pos_y[abp_pkg::COORD_W-2:0] < (abp_pkg::COORD_W-1)'(abp_pkg::SCREEN_HEIGHT));
	assign we_in = x_ok && y_ok && (src_alpha != '0);

	// RGB565 to 8 bits per channel by bit replication
	assign dr = {dest_pixel[15:11], dest_pixel[15:13]};
	assign dg = {dest_pixel[10:5], dest_pixel[10:9]};
	assign db = {dest_pixel[4:0], dest_pixel[4:2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= pix_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) we_s1 <= we_in;
		if (adv.s2) we_s2 <= we_s1;
		if (adv.s3) we_s3 <= we_s2;
	end

	// alpha 255 needs no bypass: the blend gives the source back exactly
	abp_mix u_mix_r (.clk(clk), .adv(adv), .s(src_red),   .d(dr), .a(src_alpha), .q(mr));
	abp_mix u_mix_g (.clk(clk), .adv(adv), .s(src_green), .d(dg), .a(src_alpha), .q(mg));
	abp_mix u_mix_b (.clk(clk), .adv(adv), .s(src_blue),  .d(db), .a(src_alpha), .q(mb));

	abp_index u_index (
		.clk (clk),
		.adv (adv),
		.col (pos_x[abp_pkg::COORD_W-2:0]),
		.row (pos_y[abp_pkg::COORD_W-2:0]),
		.idx (idx)
	);

	assign res_valid    = v_s3;
	assign write_enable = we_s3;
	assign pixel_index  = we_s3 ? idx : '0;
	assign pixel_color  = we_s3 ? {mr[7:3], mg[7:2], mb[7:3]} : '0;

endmodule

/* sv/abp_checker.sv */
// ----------------------------------------------------------------------------
// abp_checker
// Port-level checks for the alpha blend pixel core, bound to the top level.
// ----------------------------------------------------------------------------
`include "alpha_blend_pixel_rgb565_core_macros.svh"

module abp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pix_valid,
	input logic                            pix_stall,
	input logic signed [abp_pkg::COORD_W-1:0] pos_x,
	input logic signed [abp_pkg::COORD_W-1:0] pos_y,
	input logic [abp_pkg::CH_W-1:0]        src_red,
	input logic [abp_pkg::CH_W-1:0]        src_green,
	input logic [abp_pkg::CH_W-1:0]        src_blue,
	input logic [abp_pkg::CH_W-1:0]        src_alpha,
	input logic [abp_pkg::PIX_W-1:0]       dest_pixel,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic                            write_enable,
	input logic [abp_pkg::IDX_W-1:0]       pixel_index,
	input logic [abp_pkg::PIX_W-1:0]       pixel_color
);

	`ABP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(pixel_index) && $stable(pixel_color) && $stable(write_enable))
	`ABP_ASSERT_NOW(a_nowrite_zero, res_valid && !write_enable, pixel_index == '0 && pixel_color == '0)
	`ABP_ASSERT_NOW(a_index_range, res_valid && write_enable, pixel_index < abp_pkg::IDX_LIMIT)
	`ABP_ASSERT_NOW(a_empty_ready, !res_valid, !pix_stall)

endmodule

bind alpha_blend_pixel_rgb565_core abp_checker u_abp_checker (.*);
